// ===== hdl/http_response_header_parser_core_macros.svh =====
// ----------------------------------------------------------------------------
// HTTP response header parser - assertion macros
// Shared helpers for concurrent checks in the parser core.
// ----------------------------------------------------------------------------
`ifndef HTTP_RESPONSE_HEADER_PARSER_CORE_MACROS_SVH
`define HTTP_RESPONSE_HEADER_PARSER_CORE_MACROS_SVH

// same-cycle implication
`define HRHP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define HRHP_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/hrhp_pkg.sv =====
// ----------------------------------------------------------------------------
// HTTP response header parser - package
// Types, codes, literals and small character helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hrhp_pkg;

    localparam int LINE_BYTES_DEF   = 256;
    localparam int HEADER_LIMIT_DEF = 4096;

    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_LENGTH = 2'd1;

    localparam logic [31:0] MAX_LENGTH_RST = 32'd1048576;
    localparam logic [31:0] MIN_LENGTH_RST = 32'd116;

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NUL   = 8'h00;

    localparam int LIT_W    = 17;
    localparam int TE_LEN   = 17;
    localparam int CE_LEN   = 16;
    localparam int CL_LEN   = 14;
    localparam int ID_LEN   = 8;
    localparam int STAT_LEN = 12;

    localparam logic [8*LIT_W-1:0] LIT_TE  = "transfer-encoding";
    localparam logic [8*LIT_W-1:0] LIT_CE  = "content-encoding";
    localparam logic [8*LIT_W-1:0] LIT_CL  = "content-length";
    localparam logic [8*LIT_W-1:0] LIT_ID  = "identity";
    localparam logic [8*LIT_W-1:0] LIT_S11 = "HTTP/1.1 200";
    localparam logic [8*LIT_W-1:0] LIT_S10 = "HTTP/1.0 200";

    typedef enum logic [3:0] {
        ST_ACCEPTED    = 4'd0,
        ST_HDR_DONE    = 4'd1,
        ST_BODY        = 4'd2,
        ST_BODY_END    = 4'd3,
        ST_TOO_LONG    = 4'd4,
        ST_BAD_LINE    = 4'd5,
        ST_UNSUPPORTED = 4'd6,
        ST_EXCESS      = 4'd7,
        ST_IGNORED     = 4'd8
    } status_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HEADERS,
        PH_BODY,
        PH_DONE,
        PH_FAILED
    } phase_t;

    typedef enum logic [1:0] {
        CS_IDLE,
        CS_EXEC,
        CS_SCAN,
        CS_FINAL
    } ctrl_state_t;

    typedef enum logic [1:0] {
        VS_PRE,
        VS_TOK,
        VS_POST
    } vstate_t;

    typedef struct packed {
        logic capture;
        logic start_scan;
        logic scan_step;
        logic exec;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic needs_scan;
        logic scan_done;
    } stat_t;

    // character i (from the left) of a literal of len characters
    function automatic logic [7:0] lit_char(input logic [8*LIT_W-1:0] s, input int len,
                                            input logic [4:0] i);
        logic [7:0] c;
        c = 8'h00;
        if (int'(i) < len)
        begin
            c = s[8*(len-1-int'(i)) +: 8];
        end
        return c;
    endfunction

    function automatic logic [7:0] to_lower(input logic [7:0] b);
        logic [7:0] c;
        c = b;
        if (b >= "A" && b <= "Z")
        begin
            c = b + 8'h20;
        end
        return c;
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= "0" && b <= "9");
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SP || b == CH_TAB);
    endfunction

    function automatic logic is_name_char(input logic [7:0] b);
        return ((b >= "a" && b <= "z") || (b >= "0" && b <= "9") || b == "-");
    endfunction

endpackage

// ===== hdl/hrhp_ctrl.sv =====
// ----------------------------------------------------------------------------
// HTTP response header parser - controller
// Sequences capture, byte execution, line scan and result commit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hrhp_ctrl
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic           out_stall,
    output logic           out_valid,
    input  hrhp_pkg::stat_t stat,
    output hrhp_pkg::cmd_t  cmd
);

    hrhp_pkg::ctrl_state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;
    logic slot_free;

    assign slot_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hrhp_pkg::CS_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            hrhp_pkg::CS_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = hrhp_pkg::CS_EXEC;
                end
            end
            hrhp_pkg::CS_EXEC:
            begin
                if (stat.needs_scan)
                begin
                    cmd.start_scan = 1'b1;
                    state_next     = hrhp_pkg::CS_SCAN;
                end
                else if (slot_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = hrhp_pkg::CS_IDLE;
                end
            end
            hrhp_pkg::CS_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = hrhp_pkg::CS_FINAL;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            hrhp_pkg::CS_FINAL:
            begin
                if (slot_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = hrhp_pkg::CS_IDLE;
                end
            end
        endcase

        out_valid_next = out_valid_reg && out_stall;
        if (cmd.exec || cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
    end

    assign in_stall  = (state_reg != hrhp_pkg::CS_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== hdl/hrhp_dp.sv =====
// ----------------------------------------------------------------------------
// HTTP response header parser - datapath
// Line store, parse state, line scanner, body counter and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hrhp_dp
#(
    parameter int LINE_BYTES   = hrhp_pkg::LINE_BYTES_DEF,
    parameter int HEADER_LIMIT = hrhp_pkg::HEADER_LIMIT_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  hrhp_pkg::cmd_t                 cmd,
    output hrhp_pkg::stat_t                stat,
    input  logic                           in_cmd,
    input  logic [7:0]                     in_byte,
    input  logic                           cfg_we,
    input  logic [hrhp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data,
    output logic [3:0]                     status,
    output logic [7:0]                     body_byte,
    output logic [31:0]                    content_length
);

    localparam int LW  = $clog2(LINE_BYTES);
    localparam int HCW = $clog2(HEADER_LIMIT + 2);

    // line store
    logic [7:0] mem [LINE_BYTES];
    logic       mem_we;
    logic [7:0] rd_data_reg;
    logic [LW-1:0] rd_pos_reg;

    // item
    logic       item_cmd_reg;
    logic [7:0] item_byte_reg;

    // parse state
    hrhp_pkg::phase_t phase_reg, phase_next;
    logic [LW-1:0]  line_len_reg, line_len_next;
    logic           last_cr_reg, last_cr_next;
    logic [HCW-1:0] hdr_cnt_reg, hdr_cnt_next;
    logic           status_seen_reg, status_seen_next;
    logic           length_seen_reg, length_seen_next;
    logic [31:0]    body_len_reg, body_len_next;
    logic [31:0]    body_rcv_reg, body_rcv_next;
    logic [31:0]    max_len_reg, max_len_next;
    logic [31:0]    min_len_reg, min_len_next;

    // scanner
    logic [LW-1:0] scan_len_reg, scan_len_next;
    logic [LW-1:0] scan_idx_reg, scan_idx_next;
    logic          rd_valid_reg, rd_valid_next;
    logic          st11_reg, st11_next;
    logic          st10_reg, st10_next;
    logic          sp_ok_reg, sp_ok_next;
    logic          colon_reg, colon_next;
    logic          colon_zero_reg, colon_zero_next;
    logic          name_ok_reg, name_ok_next;
    logic          te_reg, te_next;
    logic          ce_reg, ce_next;
    logic          cl_reg, cl_next;
    hrhp_pkg::vstate_t vstate_reg, vstate_next;
    logic [3:0]    tok_k_reg, tok_k_next;
    logic          id_ok_reg, id_ok_next;
    logic          dig_ok_reg, dig_ok_next;
    logic          garbage_reg, garbage_next;
    logic [31:0]   size_reg, size_next;

    // result
    logic [3:0]  status_reg, status_next;
    logic [7:0]  body_byte_reg, body_byte_next;
    logic [31:0] clen_reg, clen_next;

    logic [HCW-1:0] cnt_inc;
    logic           lim_fail;
    logic [31:0]    body_rcv_inc;
    logic [35:0]    size_cand;
    logic [31:0]    pos32;
    logic [4:0]     pos5;
    logic [7:0]     lc;
    logic           do_tok;
    logic           status_ok, id_valid, cl_valid, hdr_ok;

    assign cnt_inc  = (hdr_cnt_reg == '1) ? hdr_cnt_reg : hdr_cnt_reg + 1'b1;
    assign lim_fail = (cnt_inc > HCW'(HEADER_LIMIT)) || (line_len_reg >= LW'(LINE_BYTES - 1))
                      || (item_byte_reg == hrhp_pkg::CH_NUL);
    assign stat.needs_scan = item_cmd_reg && (phase_reg == hrhp_pkg::PH_HEADERS) && !lim_fail
                             && (item_byte_reg == hrhp_pkg::CH_LF) && last_cr_reg;
    assign stat.scan_done  = (scan_idx_reg == scan_len_reg) && !rd_valid_reg;

    assign mem_we = cmd.exec && item_cmd_reg && (phase_reg == hrhp_pkg::PH_HEADERS) && !lim_fail
                    && (item_byte_reg != hrhp_pkg::CH_LF) && !last_cr_reg;

    assign body_rcv_inc = body_rcv_reg + 32'd1;
    // size * 10 + digit
    assign size_cand = ({4'b0, size_reg} << 3) + ({4'b0, size_reg} << 1)
                       + 36'(rd_data_reg - hrhp_pkg::CH_ZERO);
    assign pos32 = 32'(rd_pos_reg);
    assign pos5  = 5'(rd_pos_reg);
    assign lc    = hrhp_pkg::to_lower(rd_data_reg);

    assign status_ok = (scan_len_reg >= LW'(hrhp_pkg::STAT_LEN)) && (st11_reg || st10_reg)
                       && ((scan_len_reg == LW'(hrhp_pkg::STAT_LEN)) || sp_ok_reg);
    assign id_valid  = (vstate_reg != hrhp_pkg::VS_PRE) && !garbage_reg && id_ok_reg
                       && (tok_k_reg == 4'(hrhp_pkg::ID_LEN));
    assign cl_valid  = !length_seen_reg && (vstate_reg != hrhp_pkg::VS_PRE) && !garbage_reg
                       && dig_ok_reg && (size_reg >= min_len_reg);
    assign hdr_ok    = colon_reg && !colon_zero_reg && name_ok_reg && !te_reg
                       && (!ce_reg || id_valid) && (!cl_reg || cl_valid);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[line_len_reg] <= item_byte_reg;
        end
        rd_data_reg <= mem[scan_idx_reg];
        rd_pos_reg  <= scan_idx_reg;
        if (cmd.capture)
        begin
            item_cmd_reg  <= in_cmd;
            item_byte_reg <= in_byte;
        end
        status_reg    <= status_next;
        body_byte_reg <= body_byte_next;
        clen_reg      <= clen_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= hrhp_pkg::PH_IDLE;
            line_len_reg    <= '0;
            last_cr_reg     <= 1'b0;
            hdr_cnt_reg     <= '0;
            status_seen_reg <= 1'b0;
            length_seen_reg <= 1'b0;
            body_len_reg    <= '0;
            body_rcv_reg    <= '0;
            max_len_reg     <= hrhp_pkg::MAX_LENGTH_RST;
            min_len_reg     <= hrhp_pkg::MIN_LENGTH_RST;
            scan_len_reg    <= '0;
            scan_idx_reg    <= '0;
            rd_valid_reg    <= 1'b0;
            st11_reg        <= 1'b0;
            st10_reg        <= 1'b0;
            sp_ok_reg       <= 1'b0;
            colon_reg       <= 1'b0;
            colon_zero_reg  <= 1'b0;
            name_ok_reg     <= 1'b0;
            te_reg          <= 1'b0;
            ce_reg          <= 1'b0;
            cl_reg          <= 1'b0;
            vstate_reg      <= hrhp_pkg::VS_PRE;
            tok_k_reg       <= '0;
            id_ok_reg       <= 1'b0;
            dig_ok_reg      <= 1'b0;
            garbage_reg     <= 1'b0;
            size_reg        <= '0;
        end
        else
        begin
            phase_reg       <= phase_next;
            line_len_reg    <= line_len_next;
            last_cr_reg     <= last_cr_next;
            hdr_cnt_reg     <= hdr_cnt_next;
            status_seen_reg <= status_seen_next;
            length_seen_reg <= length_seen_next;
            body_len_reg    <= body_len_next;
            body_rcv_reg    <= body_rcv_next;
            max_len_reg     <= max_len_next;
            min_len_reg     <= min_len_next;
            scan_len_reg    <= scan_len_next;
            scan_idx_reg    <= scan_idx_next;
            rd_valid_reg    <= rd_valid_next;
            st11_reg        <= st11_next;
            st10_reg        <= st10_next;
            sp_ok_reg       <= sp_ok_next;
            colon_reg       <= colon_next;
            colon_zero_reg  <= colon_zero_next;
            name_ok_reg     <= name_ok_next;
            te_reg          <= te_next;
            ce_reg          <= ce_next;
            cl_reg          <= cl_next;
            vstate_reg      <= vstate_next;
            tok_k_reg       <= tok_k_next;
            id_ok_reg       <= id_ok_next;
            dig_ok_reg      <= dig_ok_next;
            garbage_reg     <= garbage_next;
            size_reg        <= size_next;
        end
    end

    always_comb
    begin
        phase_next       = phase_reg;
        line_len_next    = line_len_reg;
        last_cr_next     = last_cr_reg;
        hdr_cnt_next     = hdr_cnt_reg;
        status_seen_next = status_seen_reg;
        length_seen_next = length_seen_reg;
        body_len_next    = body_len_reg;
        body_rcv_next    = body_rcv_reg;
        max_len_next     = max_len_reg;
        min_len_next     = min_len_reg;
        scan_len_next    = scan_len_reg;
        scan_idx_next    = scan_idx_reg;
        rd_valid_next    = rd_valid_reg;
        st11_next        = st11_reg;
        st10_next        = st10_reg;
        sp_ok_next       = sp_ok_reg;
        colon_next       = colon_reg;
        colon_zero_next  = colon_zero_reg;
        name_ok_next     = name_ok_reg;
        te_next          = te_reg;
        ce_next          = ce_reg;
        cl_next          = cl_reg;
        vstate_next      = vstate_reg;
        tok_k_next       = tok_k_reg;
        id_ok_next       = id_ok_reg;
        dig_ok_next      = dig_ok_reg;
        garbage_next     = garbage_reg;
        size_next        = size_reg;
        status_next      = status_reg;
        body_byte_next   = body_byte_reg;
        clen_next        = clen_reg;
        do_tok           = 1'b0;

        if (cfg_we)
        begin
            if (cfg_index == hrhp_pkg::REG_MAX_LENGTH)
            begin
                max_len_next = cfg_data;
            end
            else if (cfg_index == hrhp_pkg::REG_MIN_LENGTH)
            begin
                min_len_next = cfg_data;
            end
        end

        if (cmd.exec)
        begin
            status_next    = hrhp_pkg::ST_IGNORED;
            body_byte_next = 8'h00;
            if (!item_cmd_reg)
            begin
                line_len_next    = '0;
                last_cr_next     = 1'b0;
                hdr_cnt_next     = '0;
                status_seen_next = 1'b0;
                length_seen_next = 1'b0;
                body_len_next    = '0;
                body_rcv_next    = '0;
                phase_next       = hrhp_pkg::PH_HEADERS;
                status_next      = hrhp_pkg::ST_ACCEPTED;
            end
            else
            begin
                unique case (phase_reg)
                    hrhp_pkg::PH_HEADERS:
                    begin
                        hdr_cnt_next = cnt_inc;
                        if (lim_fail)
                        begin
                            phase_next  = hrhp_pkg::PH_FAILED;
                            status_next = hrhp_pkg::ST_TOO_LONG;
                        end
                        else if (item_byte_reg == hrhp_pkg::CH_LF || last_cr_reg)
                        begin
                            phase_next  = hrhp_pkg::PH_FAILED;
                            status_next = hrhp_pkg::ST_BAD_LINE;
                        end
                        else
                        begin
                            line_len_next = line_len_reg + 1'b1;
                            last_cr_next  = (item_byte_reg == hrhp_pkg::CH_CR);
                            status_next   = hrhp_pkg::ST_ACCEPTED;
                        end
                    end
                    hrhp_pkg::PH_BODY:
                    begin
                        if (body_rcv_reg >= body_len_reg)
                        begin
                            phase_next  = hrhp_pkg::PH_FAILED;
                            status_next = hrhp_pkg::ST_EXCESS;
                        end
                        else
                        begin
                            body_rcv_next  = body_rcv_inc;
                            body_byte_next = item_byte_reg;
                            if (body_rcv_inc == body_len_reg)
                            begin
                                phase_next  = hrhp_pkg::PH_DONE;
                                status_next = hrhp_pkg::ST_BODY_END;
                            end
                            else
                            begin
                                status_next = hrhp_pkg::ST_BODY;
                            end
                        end
                    end
                    hrhp_pkg::PH_DONE:
                    begin
                        phase_next  = hrhp_pkg::PH_FAILED;
                        status_next = hrhp_pkg::ST_EXCESS;
                    end
                    default:
                    begin
                        status_next = hrhp_pkg::ST_IGNORED;
                    end
                endcase
            end
            clen_next = body_len_next;
        end

        if (cmd.start_scan)
        begin
            hdr_cnt_next    = cnt_inc;
            scan_len_next   = line_len_reg - 1'b1;   // drop the CR
            scan_idx_next   = '0;
            rd_valid_next   = 1'b0;
            st11_next       = 1'b1;
            st10_next       = 1'b1;
            sp_ok_next      = 1'b0;
            colon_next      = 1'b0;
            colon_zero_next = 1'b0;
            name_ok_next    = 1'b1;
            te_next         = 1'b1;
            ce_next         = 1'b1;
            cl_next         = 1'b1;
            vstate_next     = hrhp_pkg::VS_PRE;
            tok_k_next      = '0;
            id_ok_next      = 1'b1;
            dig_ok_next     = 1'b1;
            garbage_next    = 1'b0;
            size_next       = '0;
        end

        if (cmd.scan_step)
        begin
            rd_valid_next = (scan_idx_reg < scan_len_reg);
            if (scan_idx_reg < scan_len_reg)
            begin
                scan_idx_next = scan_idx_reg + 1'b1;
            end

            if (rd_valid_reg)
            begin
                // status line checks
                if (pos32 < 32'(hrhp_pkg::STAT_LEN))
                begin
                    st11_next = st11_reg && (rd_data_reg == hrhp_pkg::lit_char(
                                hrhp_pkg::LIT_S11, hrhp_pkg::STAT_LEN, pos5));
                    st10_next = st10_reg && (rd_data_reg == hrhp_pkg::lit_char(
                                hrhp_pkg::LIT_S10, hrhp_pkg::STAT_LEN, pos5));
                end
                if (pos32 == 32'(hrhp_pkg::STAT_LEN))
                begin
                    sp_ok_next = (rd_data_reg == hrhp_pkg::CH_SP);
                end

                // header name up to the first colon
                if (!colon_reg)
                begin
                    if (rd_data_reg == hrhp_pkg::CH_COLON)
                    begin
                        colon_next      = 1'b1;
                        colon_zero_next = (pos32 == 32'd0);
                        te_next = te_reg && (pos32 == 32'(hrhp_pkg::TE_LEN));
                        ce_next = ce_reg && (pos32 == 32'(hrhp_pkg::CE_LEN));
                        cl_next = cl_reg && (pos32 == 32'(hrhp_pkg::CL_LEN));
                    end
                    else
                    begin
                        name_ok_next = name_ok_reg && hrhp_pkg::is_name_char(lc);
                        te_next = te_reg && (pos32 < 32'(hrhp_pkg::TE_LEN)) && (lc ==
                                  hrhp_pkg::lit_char(hrhp_pkg::LIT_TE, hrhp_pkg::TE_LEN, pos5));
                        ce_next = ce_reg && (pos32 < 32'(hrhp_pkg::CE_LEN)) && (lc ==
                                  hrhp_pkg::lit_char(hrhp_pkg::LIT_CE, hrhp_pkg::CE_LEN, pos5));
                        cl_next = cl_reg && (pos32 < 32'(hrhp_pkg::CL_LEN)) && (lc ==
                                  hrhp_pkg::lit_char(hrhp_pkg::LIT_CL, hrhp_pkg::CL_LEN, pos5));
                    end
                end
                else
                begin
                    // value: leading blanks, one token, trailing blanks
                    unique case (vstate_reg)
                        hrhp_pkg::VS_PRE:
                        begin
                            if (!hrhp_pkg::is_blank(rd_data_reg))
                            begin
                                vstate_next = hrhp_pkg::VS_TOK;
                                do_tok      = 1'b1;
                            end
                        end
                        hrhp_pkg::VS_TOK:
                        begin
                            if (hrhp_pkg::is_blank(rd_data_reg))
                            begin
                                vstate_next = hrhp_pkg::VS_POST;
                            end
                            else
                            begin
                                do_tok = 1'b1;
                            end
                        end
                        default:
                        begin
                            if (!hrhp_pkg::is_blank(rd_data_reg))
                            begin
                                garbage_next = 1'b1;
                            end
                        end
                    endcase

                    if (do_tok)
                    begin
                        id_ok_next = id_ok_reg && (tok_k_reg < 4'(hrhp_pkg::ID_LEN))
                                     && (rd_data_reg == hrhp_pkg::lit_char(
                                         hrhp_pkg::LIT_ID, hrhp_pkg::ID_LEN, 5'(tok_k_reg)));
                        if (tok_k_reg < 4'(hrhp_pkg::ID_LEN + 1))
                        begin
                            tok_k_next = tok_k_reg + 1'b1;
                        end
                        if (hrhp_pkg::is_digit(rd_data_reg) && (size_cand <= {4'b0, max_len_reg}))
                        begin
                            size_next = size_cand[31:0];
                        end
                        else
                        begin
                            dig_ok_next = 1'b0;
                        end
                    end
                end
            end
        end

        if (cmd.commit)
        begin
            line_len_next  = '0;
            last_cr_next   = 1'b0;
            body_byte_next = 8'h00;
            status_next    = hrhp_pkg::ST_ACCEPTED;
            if (!status_seen_reg)
            begin
                if (status_ok)
                begin
                    status_seen_next = 1'b1;
                end
                else
                begin
                    phase_next  = hrhp_pkg::PH_FAILED;
                    status_next = hrhp_pkg::ST_UNSUPPORTED;
                end
            end
            else if (scan_len_reg == '0)
            begin
                if (!length_seen_reg)
                begin
                    phase_next  = hrhp_pkg::PH_FAILED;
                    status_next = hrhp_pkg::ST_UNSUPPORTED;
                end
                else
                begin
                    phase_next  = (body_len_reg == 32'd0) ? hrhp_pkg::PH_DONE
                                                          : hrhp_pkg::PH_BODY;
                    status_next = hrhp_pkg::ST_HDR_DONE;
                end
            end
            else if (hdr_ok)
            begin
                if (cl_reg)
                begin
                    body_len_next    = size_reg;
                    length_seen_next = 1'b1;
                end
            end
            else
            begin
                phase_next  = hrhp_pkg::PH_FAILED;
                status_next = hrhp_pkg::ST_UNSUPPORTED;
            end
            clen_next = body_len_next;
        end
    end

    assign status         = status_reg;
    assign body_byte      = body_byte_reg;
    assign content_length = clen_reg;

endmodule

// ===== hdl/http_response_header_parser_core.sv =====
// ----------------------------------------------------------------------------
// HTTP response header parser core
// Byte-wise HTTP response header check with body length counting.
// ----------------------------------------------------------------------------
//  channel | signals                                       | handshake
//  --------+-----------------------------------------------+-----------------
//  input   | cmd, data_byte                                | in_valid/in_stall
//  output  | status, body_byte, content_length             | out_valid/out_stall
//  config  | cfg_index, cfg_data                           | cfg_valid/cfg_ready
//
//  A plain byte or start is captured, then executed. At a line ending the
//  scanner reads the stored line (CR dropped) once, one byte per cycle
//  through its single registered read port, then commits; a blank line
//  is committed without a read.
//  Reset clears all control state; the line store needs no clearing.
//  A result waits in the output register while the next item is taken in;
//  it is only executed once that register is free.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "http_response_header_parser_core_macros.svh"

module http_response_header_parser_core
#(
    parameter int LINE_BYTES   = hrhp_pkg::LINE_BYTES_DEF,
    parameter int HEADER_LIMIT = hrhp_pkg::HEADER_LIMIT_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           cmd,
    input  logic [7:0]                     data_byte,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [3:0]                     status,
    output logic [7:0]                     body_byte,
    output logic [31:0]                    content_length,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [hrhp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                    cfg_data
);

    hrhp_pkg::cmd_t  ctl_cmd;
    hrhp_pkg::stat_t dp_stat;

    assign cfg_ready = 1'b1;

    hrhp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .stat      (dp_stat),
        .cmd       (ctl_cmd)
    );

    hrhp_dp
    #(
        .LINE_BYTES   (LINE_BYTES),
        .HEADER_LIMIT (HEADER_LIMIT)
    )
    u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (ctl_cmd),
        .stat           (dp_stat),
        .in_cmd         (cmd),
        .in_byte        (data_byte),
        .cfg_we         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .status         (status),
        .body_byte      (body_byte),
        .content_length (content_length)
    );

    // an accepted item keeps the input side busy in the cycle after it
    `HRHP_ASSERT_NXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall,
                     "input accepted twice in a row")

    // a result is only loaded into a free output register
    `HRHP_ASSERT_IMP(a_emit_slot_free, clk, rst_n, ctl_cmd.exec || ctl_cmd.commit,
                     !out_valid || !out_stall, "result overwrote a pending item")

    // last body byte implies a nonzero length
    `HRHP_ASSERT_IMP(a_body_end_len, clk, rst_n,
                     out_valid && status == hrhp_pkg::ST_BODY_END,
                     content_length != 32'd0, "body end with zero length")

endmodule
